@@ rtl/hwp_pkg.sv @@
// ----------------------------------------------------------------------------
// hwp_pkg
// Shared types and constants for the Haar wavelet pass unit.
// ----------------------------------------------------------------------------
package hwp_pkg;

    localparam int DEF_MAX_COLUMNS = 4096;
    localparam int DEF_MAX_ROWS    = 4096;

    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 24;
    localparam int COUNT_W  = 13;
    localparam int BAND_W   = 2;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd2;

    // direction codes
    localparam logic DIR_VERTICAL   = 1'b0;
    localparam logic DIR_HORIZONTAL = 1'b1;

    // band codes
    localparam logic [BAND_W-1:0] BAND_LOW  = 2'd0;
    localparam logic [BAND_W-1:0] BAND_HIGH = 2'd1;
    localparam logic [BAND_W-1:0] BAND_COPY = 2'd2;

    // what an accepted sample produces
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PAIR,
        KIND_COPY
    } kind_t;

    typedef struct packed {
        logic [INDEX_W-1:0]         out_index;
        logic signed [SAMPLE_W-1:0] coefficient;
        logic [BAND_W-1:0]          band;
        logic                       run_last;
    } result_t;

endpackage

@@ rtl/haar_wavelet_pass_unit.sv @@
// ----------------------------------------------------------------------------
// haar_wavelet_pass_unit
// One vertical or horizontal integer Haar pass over a raster sample stream.
// ----------------------------------------------------------------------------
// A result passes through the stage B registers and the output queue before it
// can be taken. Throughput: one sample per cycle while s_ready is high; results
// leave at one per cycle, so on odd rows of a vertical pass the m_ side holds
// input back. Line buffer: one read and one write port, read data registered.
// Reset: config returns to defaults, position restarts; line buffer is not
// cleared. settle_reg holds s_ready low after reset and a mapped config write.
module haar_wavelet_pass_unit
    import hwp_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [COUNT_W-1:0]         cfg_data,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [INDEX_W-1:0]         m_out_index,
    output logic signed [SAMPLE_W-1:0] m_coefficient,
    output logic [BAND_W-1:0]          m_band,
    output logic                       m_run_last
);

    localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CCW = $clog2(MAX_COLUMNS + 1);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int PW  = CCW + RCW;
    localparam int FIFO_DEPTH = 8;
    localparam int FPW = $clog2(FIFO_DEPTH);
    localparam int FCW = $clog2(FIFO_DEPTH + 1);

    // ---------------- configuration ----------------
    logic               direction_reg;
    logic [COUNT_W-1:0] row_count_reg;
    logic [COUNT_W-1:0] column_count_reg;
    logic               settle_reg;
    logic               cfg_hit;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && cfg_ready &&
                       (cfg_index == CFG_DIRECTION || cfg_index == CFG_ROW_COUNT ||
                        cfg_index == CFG_COLUMN_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg    <= DIR_VERTICAL;
            row_count_reg    <= COUNT_W'(1);
            column_count_reg <= COUNT_W'(1);
            settle_reg       <= 1'b1;
        end else begin
            settle_reg <= cfg_hit;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_DIRECTION:    direction_reg    <= cfg_data[0];
                    CFG_ROW_COUNT:    row_count_reg    <= cfg_data;
                    CFG_COLUMN_COUNT: column_count_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // clamped counts
    logic [CCW-1:0] cols;
    logic [RCW-1:0] rows;

    always_comb begin
        if (column_count_reg == '0)
            cols = CCW'(1);
        else if (32'(column_count_reg) > 32'(MAX_COLUMNS))
            cols = CCW'(MAX_COLUMNS);
        else
            cols = CCW'(column_count_reg);
        if (row_count_reg == '0)
            rows = RCW'(1);
        else if (32'(row_count_reg) > 32'(MAX_ROWS))
            rows = RCW'(MAX_ROWS);
        else
            rows = RCW'(row_count_reg);
    end

    // (rows/2)*cols: offset of the high band in vertical mode
    logic [PW-1:0]      half_prod;
    logic [INDEX_W-1:0] half_off_reg;
    logic [INDEX_W-1:0] cols_ext;
    logic [INDEX_W-1:0] cols_half;

    assign half_prod = PW'(rows >> 1) * PW'(cols);
    assign cols_ext  = INDEX_W'(cols);
    assign cols_half = INDEX_W'(cols >> 1);

    always_ff @(posedge aclk) begin
        half_off_reg <= INDEX_W'(half_prod);
    end

    // ---------------- position tracking ----------------
    logic [CIW-1:0]     col_pos_reg, col_pos_next;
    logic [RIW-1:0]     row_pos_reg, row_pos_next;
    logic [INDEX_W-1:0] row_base_reg, row_base_next;   // r*C
    logic [INDEX_W-1:0] pair_base_reg, pair_base_next; // (r/2)*C
    logic               col_last, row_last;
    logic               s_fire;

    assign col_last = (CCW'(col_pos_reg) + CCW'(1)) == cols;
    assign row_last = (RCW'(row_pos_reg) + RCW'(1)) == rows;

    // ---------------- output queue ----------------
    result_t            fifo_mem [FIFO_DEPTH];
    logic [FPW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [FCW-1:0]     count_reg;
    logic [1:0]         push_n;
    logic               pop;

    // ---------------- stage B registers ----------------
    logic               valid_b_reg;
    kind_t              kind_b_reg;
    logic               dir_b_reg;
    logic [SAMPLE_W-1:0] sample_b_reg;
    logic [INDEX_W-1:0] idx_low_b_reg, idx_high_b_reg;

    // room for this word's results plus what stage B still holds
    assign s_ready = !settle_reg &&
                     (32'(count_reg) + 32'(push_n) + 2 <= FIFO_DEPTH);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        col_pos_next   = col_pos_reg;
        row_pos_next   = row_pos_reg;
        row_base_next  = row_base_reg;
        pair_base_next = pair_base_reg;
        if (s_fire) begin
            if (col_last) begin
                col_pos_next = '0;
                if (row_last) begin
                    row_pos_next   = '0;
                    row_base_next  = '0;
                    pair_base_next = '0;
                end else begin
                    row_pos_next  = row_pos_reg + RIW'(1);
                    row_base_next = row_base_reg + cols_ext;
                    if (row_pos_reg[0])
                        pair_base_next = pair_base_reg + cols_ext;
                end
            end else begin
                col_pos_next = col_pos_reg + CIW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            row_base_reg  <= '0;
            pair_base_reg <= '0;
        end else if (cfg_hit) begin
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            row_base_reg  <= '0;
            pair_base_reg <= '0;
        end else begin
            col_pos_reg   <= col_pos_next;
            row_pos_reg   <= row_pos_next;
            row_base_reg  <= row_base_next;
            pair_base_reg <= pair_base_next;
        end
    end

    // ---------------- stage A decode ----------------
    kind_t              kind_a;
    logic [INDEX_W-1:0] idx_low_a, idx_high_a;
    logic [INDEX_W-1:0] col_ext, col_half;
    logic               line_wr, held_wr;

    assign col_ext  = INDEX_W'(col_pos_reg);
    assign col_half = INDEX_W'(col_pos_reg >> 1);

    always_comb begin
        kind_a     = KIND_NONE;
        idx_low_a  = row_base_reg + col_ext;
        idx_high_a = row_base_reg + col_ext;
        line_wr    = 1'b0;
        held_wr    = 1'b0;
        if (direction_reg == DIR_VERTICAL) begin
            if (!row_pos_reg[0]) begin
                if (row_last)
                    kind_a = KIND_COPY;
                else
                    line_wr = s_fire;
            end else begin
                kind_a     = KIND_PAIR;
                idx_low_a  = pair_base_reg + col_ext;
                idx_high_a = pair_base_reg + half_off_reg + col_ext;
            end
        end else begin
            if (!col_pos_reg[0]) begin
                if (col_last)
                    kind_a = KIND_COPY;
                else
                    held_wr = s_fire;
            end else begin
                kind_a     = KIND_PAIR;
                idx_low_a  = row_base_reg + col_half;
                idx_high_a = row_base_reg + cols_half + col_half;
            end
        end
    end

    // ---------------- line buffer and held sample ----------------
    // Even row entry is written at least one accept before its odd row reads
    // it, so the registered read always sees the new value.
    logic [SAMPLE_W-1:0] line_mem [MAX_COLUMNS];
    logic [SAMPLE_W-1:0] line_rd_reg;
    logic [SAMPLE_W-1:0] held_reg;

    always_ff @(posedge aclk) begin
        if (line_wr)
            line_mem[col_pos_reg] <= s_sample;
        if (s_fire)
            line_rd_reg <= line_mem[col_pos_reg];
    end

    always_ff @(posedge aclk) begin
        if (held_wr)
            held_reg <= s_sample;
    end

    // ---------------- stage B ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_b_reg <= 1'b0;
        end else begin
            valid_b_reg <= s_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_b_reg     <= kind_a;
            dir_b_reg      <= direction_reg;
            sample_b_reg   <= s_sample;
            idx_low_b_reg  <= idx_low_a;
            idx_high_b_reg <= idx_high_a;
        end
    end

    logic [SAMPLE_W-1:0] first_b, sum_b, diff_b;
    result_t             res0, res1;

    assign first_b = (dir_b_reg == DIR_VERTICAL) ? line_rd_reg : held_reg;
    assign sum_b   = first_b + sample_b_reg;
    assign diff_b  = first_b - sample_b_reg;

    always_comb begin
        push_n = 2'd0;
        res0   = '{out_index: idx_low_b_reg, coefficient: sample_b_reg,
                   band: BAND_COPY, run_last: 1'b1};
        res1   = '{out_index: idx_high_b_reg, coefficient: diff_b,
                   band: BAND_HIGH, run_last: 1'b1};
        if (valid_b_reg) begin
            unique case (kind_b_reg)
                KIND_PAIR: begin
                    push_n = 2'd2;
                    res0 = '{out_index: idx_low_b_reg,
                             coefficient: {sum_b[SAMPLE_W-1], sum_b[SAMPLE_W-1:1]},
                             band: BAND_LOW, run_last: 1'b0};
                end
                KIND_COPY: push_n = 2'd1;
                KIND_NONE: push_n = 2'd0;
                default:   push_n = 2'd0;
            endcase
        end
    end

    // ---------------- output queue ----------------
    assign m_valid       = count_reg != '0;
    assign pop           = m_valid && m_ready;
    assign m_out_index   = fifo_mem[rd_ptr_reg].out_index;
    assign m_coefficient = fifo_mem[rd_ptr_reg].coefficient;
    assign m_band        = fifo_mem[rd_ptr_reg].band;
    assign m_run_last    = fifo_mem[rd_ptr_reg].run_last;

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0)
            fifo_mem[wr_ptr_reg] <= res0;
        if (push_n == 2'd2)
            fifo_mem[wr_ptr_reg + FPW'(1)] <= res1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FPW'(push_n);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FPW'(1);
            count_reg <= count_reg + FCW'(push_n) - FCW'(pop);
        end
    end

endmodule

@@ rtl/hwp_checker.sv @@
// ----------------------------------------------------------------------------
// hwp_checker
// Port-level checks for the Haar wavelet pass unit, bound to the top level.
// ----------------------------------------------------------------------------
module hwp_checker
    import hwp_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic [CFG_IDX_W-1:0]       cfg_index,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [INDEX_W-1:0]         m_out_index,
    input logic signed [SAMPLE_W-1:0] m_coefficient,
    input logic [BAND_W-1:0]          m_band,
    input logic                       m_run_last
);

    // a low word is always followed at once by its high word
    a_high_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_run_last) |=> (m_valid && m_band == BAND_HIGH))
        else $error("high word missing after low word");

    // only the low word of a pair leaves run_last clear
    a_last_vs_band: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_band == BAND_LOW && !m_run_last) ||
                     (m_band == BAND_HIGH && m_run_last) ||
                     (m_band == BAND_COPY && m_run_last)))
        else $error("band and run_last disagree");

    // input is held off in the cycle after a mapped register write
    a_cfg_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready &&
         (cfg_index == CFG_DIRECTION || cfg_index == CFG_ROW_COUNT ||
          cfg_index == CFG_COLUMN_COUNT)) |=> !(s_valid && s_ready))
        else $error("sample accepted right after config write");

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_index) &&
                                   $stable(m_coefficient) && $stable(m_band)))
        else $error("result word changed while stalled");

endmodule

bind haar_wavelet_pass_unit hwp_checker u_hwp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_index   (m_out_index),
    .m_coefficient (m_coefficient),
    .m_band        (m_band),
    .m_run_last    (m_run_last)
);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for haar_wavelet_pass_unit. A coefficient tracker
// follows the frame position, line buffer and held word to work out every
// low, high and copied word, and checks the m_ side against it in order.
// Directed frames cover the wrap and clamp corners; random frames follow.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import hwp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped register slot
    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 20;
    localparam int TARGET_WORDS  = 1300;

    class haar_coef_tracker;
        logic                dir;
        logic [COUNT_W-1:0]  rows_reg;
        logic [COUNT_W-1:0]  cols_reg;
        int unsigned         row_at;
        int unsigned         col_at;
        logic [SAMPLE_W-1:0] line_buf [DEF_MAX_COLUMNS];
        logic [SAMPLE_W-1:0] held_word;
        result_t             pending_coefs [$];
        int unsigned         errors;

        function new();
            dir      = DIR_VERTICAL;
            rows_reg = COUNT_W'(1);
            cols_reg = COUNT_W'(1);
            row_at   = 0;
            col_at   = 0;
            errors   = 0;
        endfunction

        // any mapped register write restarts the frame
        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [COUNT_W-1:0] data);
            case (idx)
                CFG_DIRECTION:    dir = data[0];
                CFG_ROW_COUNT:    rows_reg = data;
                CFG_COLUMN_COUNT: cols_reg = data;
                default:          return;
            endcase
            row_at = 0;
            col_at = 0;
        endfunction

        function int unsigned clamp_count(input logic [COUNT_W-1:0] v,
                                          input int unsigned top);
            if (v == 0) return 1;
            if (v > top) return top;
            return 32'(v);
        endfunction

        function void note(input int unsigned at, input logic [SAMPLE_W-1:0] coef,
                           input logic [BAND_W-1:0] band, input logic last);
            result_t r;
            r.out_index   = at[INDEX_W-1:0];
            r.coefficient = coef;
            r.band        = band;
            r.run_last    = last;
            pending_coefs.push_back(r);
        endfunction

        function void push_pair(input int unsigned lo_at, input int unsigned hi_at,
                                input logic [SAMPLE_W-1:0] a,
                                input logic [SAMPLE_W-1:0] b);
            logic [SAMPLE_W-1:0] total;
            logic [SAMPLE_W-1:0] diff;
            total = a + b;
            diff  = a - b;
            // low is the wrapped sum shifted right, sign kept
            note(lo_at, {total[SAMPLE_W-1], total[SAMPLE_W-1:1]}, BAND_LOW, 1'b0);
            note(hi_at, diff, BAND_HIGH, 1'b1);
        endfunction

        function void take_sample(input logic [SAMPLE_W-1:0] s);
            int unsigned rows, cols, r, c;
            rows = clamp_count(rows_reg, DEF_MAX_ROWS);
            cols = clamp_count(cols_reg, DEF_MAX_COLUMNS);
            r = row_at;
            c = col_at;
            if (dir == DIR_VERTICAL) begin
                if (r % 2 == 0) begin
                    if (r + 1 < rows) line_buf[c] = s;
                    else note((rows - 1) * cols + c, s, BAND_COPY, 1'b1);
                end else begin
                    push_pair(r / 2 * cols + c, (r / 2 + rows / 2) * cols + c,
                              line_buf[c], s);
                end
            end else if (c % 2 == 0) begin
                if (c + 1 < cols) held_word = s;
                else note(r * cols + cols - 1, s, BAND_COPY, 1'b1);
            end else begin
                push_pair(r * cols + c / 2, r * cols + cols / 2 + c / 2, held_word, s);
            end
            c++;
            if (c >= cols) begin
                c = 0;
                r = (r + 1 >= rows) ? 0 : r + 1;
            end
            row_at = r;
            col_at = c;
        endfunction

        function void check_coef(input logic [INDEX_W-1:0] idx,
                                 input logic [SAMPLE_W-1:0] coef,
                                 input logic [BAND_W-1:0] band, input logic last);
            result_t want;
            if (pending_coefs.size() == 0) begin
                $error("unexpected word: out_index %0d coefficient %0d",
                       idx, $signed(coef));
                errors++;
                return;
            end
            want = pending_coefs.pop_front();
            if (idx !== want.out_index) begin
                $error("out_index: expected %0d, got %0d", want.out_index, idx);
                errors++;
            end
            if (coef !== want.coefficient) begin
                $error("coefficient: expected %0d, got %0d",
                       $signed(want.coefficient), $signed(coef));
                errors++;
            end
            if (band !== want.band) begin
                $error("band: expected %0d, got %0d", want.band, band);
                errors++;
            end
            if (last !== want.run_last) begin
                $error("run_last: expected %0d, got %0d", want.run_last, last);
                errors++;
            end
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn   = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [COUNT_W-1:0]         cfg_data  = '0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample  = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    logic [INDEX_W-1:0]         m_out_index;
    logic signed [SAMPLE_W-1:0] m_coefficient;
    logic [BAND_W-1:0]          m_band;
    logic                       m_run_last;

    haar_coef_tracker coefs = new();
    int unsigned      idle_cycles = 0;

    haar_wavelet_pass_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_index   (m_out_index),
        .m_coefficient (m_coefficient),
        .m_band        (m_band),
        .m_run_last    (m_run_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // handshakes are observed here only; the watchdog trips on a long silence
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) coefs.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) coefs.take_sample(s_sample);
            if (m_valid && m_ready)
                coefs.check_coef(m_out_index, m_coefficient, m_band, m_run_last);
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // receiver: always ready, coin flips, or alternating ready runs and stalls
    initial begin
        int unsigned mode_left, stall_mode, run;
        mode_left = 0;
        stall_mode = 0;
        run = 0;
        forever begin
            @(negedge aclk);
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(50, 400);
                run        = 0;
            end
            mode_left--;
            case (stall_mode)
                0: m_ready = 1'b1;
                1: m_ready = 1'($urandom_range(0, 1));
                default: begin
                    if (run == 0) begin
                        m_ready = !m_ready;
                        run = m_ready ? $urandom_range(1, 8) : $urandom_range(1, 16);
                    end
                    run--;
                end
            endcase
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] v);
        @(negedge aclk);
        s_valid  = 1'b1;
        s_sample = v;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause_sender(input int unsigned n);
        @(negedge aclk);
        s_valid = 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    // hold the sender until every expected word is out, then for SETTLE_CYCLES more
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (coefs.pending_coefs.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [COUNT_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return COUNT_W'(4096);
            2:       return COUNT_W'($urandom_range(4097, 8191));
            3:       return COUNT_W'($urandom_range(10, 4095));
            default: return COUNT_W'($urandom_range(1, 9));
        endcase
    endfunction

    initial begin
        logic [SAMPLE_W-1:0] horiz_words [8];
        logic [SAMPLE_W-1:0] vert_words [6];
        logic [SAMPLE_W-1:0] word;
        int unsigned         items_sent, phase_len, burst_left;

        items_sent = 0;
        burst_left = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset defaults: 1x1 vertical, every word copied through
        send_sample(16'h7FFF);
        send_sample(16'h8000);

        // 2x3 horizontal: pair then last-column copy, then wrap to row 0
        settle();
        write_cfg(CFG_DIRECTION, COUNT_W'(DIR_HORIZONTAL));
        write_cfg(CFG_ROW_COUNT, 13'd2);
        write_cfg(CFG_COLUMN_COUNT, 13'd3);
        horiz_words = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000,
                        16'h0005, 16'hFFFD};
        foreach (horiz_words[i]) send_sample(horiz_words[i]);

        // 3x2 vertical: one row pair, then the last row copied
        settle();
        write_cfg(CFG_DIRECTION, COUNT_W'(DIR_VERTICAL));
        write_cfg(CFG_ROW_COUNT, 13'd3);
        write_cfg(CFG_COLUMN_COUNT, 13'd2);
        vert_words = '{16'h8000, 16'hFFFF, 16'h8000, 16'h0001, 16'h0007, 16'hFFF9};
        foreach (vert_words[i]) send_sample(vert_words[i]);

        // half a pair, then a write restarts the frame; counts out of range clamp
        send_sample(16'h1234);
        settle();
        write_cfg(CFG_COLUMN_COUNT, 13'd0);
        write_cfg(CFG_ROW_COUNT, 13'd8191);
        send_sample(16'h0100);
        send_sample(16'h0300);

        // unmapped register write must not break the pair in progress
        send_sample(16'h4000);
        settle();
        write_cfg(CFG_SPARE, 13'h1FFF);
        send_sample(16'h4000);

        while (items_sent < TARGET_WORDS) begin
            settle();
            if ($urandom_range(0, 3) != 0) write_cfg(CFG_DIRECTION, COUNT_W'($urandom));
            if ($urandom_range(0, 3) != 0) write_cfg(CFG_ROW_COUNT, pick_count());
            if ($urandom_range(0, 3) != 0) write_cfg(CFG_COLUMN_COUNT, pick_count());
            if ($urandom_range(0, 15) == 0) write_cfg(CFG_SPARE, COUNT_W'($urandom));
            phase_len = $urandom_range(20, 120);
            repeat (phase_len) begin
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 24);
                    if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
                end
                burst_left--;
                case ($urandom_range(0, 9))
                    0:       word = 16'h7FFF;
                    1:       word = 16'h8000;
                    2:       word = 16'hFFFF;
                    3:       word = 16'h0000;
                    default: word = SAMPLE_W'($urandom);
                endcase
                send_sample(word);
                items_sent++;
            end
        end

        settle();
        repeat (END_CYCLES) @(negedge aclk);
        if (coefs.errors == 0 && coefs.pending_coefs.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ haar_wavelet_pass_unit.f @@
rtl/hwp_pkg.sv
rtl/haar_wavelet_pass_unit.sv
rtl/hwp_checker.sv
tb/sv/testbench.sv
